>>> rtl/assert_macros.svh
// Assertion macros used by the checker of the SHA-256 stream hasher.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SHA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("SHA-256 hasher assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("SHA-256 hasher assertion failed");

`endif

>>> rtl/sha256_pkg.sv
// Shared types, constants and functions of the SHA-256 byte stream hasher.
// No dependencies; used by the hasher, schedule and core via scoped names.
`timescale 1ns / 1ps

package sha256_pkg;

    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [63:0] BYTE_BITS = 64'd8;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_TAB [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic       push;
        logic       word_done;
        logic       shift;
        logic [7:0] data;
    } t_sched_ctl;

    typedef struct packed {
        logic       init;
        logic       load;
        logic       round;
        logic       finish;
        logic [5:0] rnd;
    } t_core_ctl;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

>>> rtl/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher: top level with the sequencer and the stream ports.
// Depends on sha256_pkg, sha256_sched and sha256_core.
`timescale 1ns / 1ps

// Bytes are taken one per cycle while the input is ready. The 64th byte of a
// block starts a compression (a load step, 64 rounds on the single round unit
// and a step to fold the result into the chaining words), during which the
// input is not ready. A transfer with tlast set then pads the message one byte
// per cycle up to the end of the block, runs one or two further compressions
// and offers the eight digest words, one per cycle while the output is ready,
// most significant first; the input stays not ready until the eighth word is
// taken. A transfer with tuser low carries no byte; with tlast also low it does
// nothing. After the digest the hash state returns to its initial values.

module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] msg_byte
    input  logic        s_axis_tuser,  // byte_present
    input  logic        s_axis_tlast,  // msg_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index, zeros above
    output logic        m_axis_tlast   // digest_last
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bit_len, n_bit_len;
    logic [5:0]  r_rnd, n_rnd;
    logic [2:0]  r_idx, n_idx;
    logic        r_end_pend, n_end_pend;
    logic        r_in_pad, n_in_pad;
    logic        r_pad_first, n_pad_first;
    logic        r_len_ok, n_len_ok;
    logic        r_final, n_final;

    sha256_pkg::t_sched_ctl sched_ctl;
    sha256_pkg::t_core_ctl  core_ctl;
    logic [31:0] w_word;
    logic [31:0] chain_word;
    logic        in_xfer;
    logic        out_xfer;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata = {5'd0, r_idx, chain_word};
    assign m_axis_tlast = (r_idx == sha256_pkg::LAST_WORD);

    assign len_byte = r_bit_len[{~r_fill[2:0], 3'b000} +: 8];
    assign pad_byte = r_pad_first ? sha256_pkg::PAD_MARK :
                      ((r_len_ok && (r_fill[5:3] == 3'b111)) ? len_byte : 8'h00);

    sha256_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w   (w_word)
    );

    sha256_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_w     (w_word),
        .i_idx   (r_idx),
        .o_word  (chain_word)
    );

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_bit_len   = r_bit_len;
        n_rnd       = r_rnd;
        n_idx       = r_idx;
        n_end_pend  = r_end_pend;
        n_in_pad    = r_in_pad;
        n_pad_first = r_pad_first;
        n_len_ok    = r_len_ok;
        n_final     = r_final;
        sched_ctl   = '0;
        core_ctl    = '0;
        core_ctl.rnd = r_rnd;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_axis_tuser) begin
                        sched_ctl.push      = 1'b1;
                        sched_ctl.data      = s_axis_tdata;
                        sched_ctl.word_done = (r_fill[1:0] == 2'b11);
                        n_bit_len = r_bit_len + sha256_pkg::BYTE_BITS;
                        n_fill    = r_fill + 6'd1;
                    end
                    if (s_axis_tuser && (r_fill == sha256_pkg::LAST_BYTE)) begin
                        n_end_pend = s_axis_tlast;
                        n_state    = ST_LOAD;
                    end else if (s_axis_tlast) begin
                        n_state     = ST_PAD;
                        n_in_pad    = 1'b1;
                        n_pad_first = 1'b1;
                        n_len_ok    = 1'b0;
                    end
                end
            end
            ST_LOAD: begin
                core_ctl.load = 1'b1;
                n_rnd   = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                core_ctl.round  = 1'b1;
                sched_ctl.shift = 1'b1;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == sha256_pkg::LAST_ROUND) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                core_ctl.finish = 1'b1;
                if (r_in_pad) begin
                    if (r_final) begin
                        n_idx   = '0;
                        n_state = ST_OUT;
                    end else begin
                        n_len_ok = 1'b1;
                        n_state  = ST_PAD;
                    end
                end else if (r_end_pend) begin
                    n_end_pend  = 1'b0;
                    n_in_pad    = 1'b1;
                    n_pad_first = 1'b1;
                    n_len_ok    = 1'b0;
                    n_state     = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                sched_ctl.push      = 1'b1;
                sched_ctl.data      = pad_byte;
                sched_ctl.word_done = (r_fill[1:0] == 2'b11);
                n_fill      = r_fill + 6'd1;
                n_pad_first = 1'b0;
                if (r_pad_first && (r_fill[5:3] != 3'b111)) begin
                    n_len_ok = 1'b1;
                end
                if (r_fill == sha256_pkg::LAST_BYTE) begin
                    n_final = r_len_ok;
                    n_state = ST_LOAD;
                end
            end
            ST_OUT: begin
                if (out_xfer) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == sha256_pkg::LAST_WORD) begin
                        core_ctl.init = 1'b1;
                        n_fill    = '0;
                        n_bit_len = '0;
                        n_in_pad  = 1'b0;
                        n_final   = 1'b0;
                        n_len_ok  = 1'b0;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_bit_len   <= '0;
            r_rnd       <= '0;
            r_idx       <= '0;
            r_end_pend  <= 1'b0;
            r_in_pad    <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_ok    <= 1'b0;
            r_final     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_bit_len   <= n_bit_len;
            r_rnd       <= n_rnd;
            r_idx       <= n_idx;
            r_end_pend  <= n_end_pend;
            r_in_pad    <= n_in_pad;
            r_pad_first <= n_pad_first;
            r_len_ok    <= n_len_ok;
            r_final     <= n_final;
        end
    end

endmodule

>>> rtl/sha256_sched.sv
// Message schedule: packs bytes into big-endian words and holds a sliding
// window of sixteen words that expands the schedule one word per round. Uses sha256_pkg.
`timescale 1ns / 1ps

module sha256_sched (
    input  logic                   i_clk,
    input  sha256_pkg::t_sched_ctl i_ctl,
    output logic [31:0]            o_w
);

    logic [23:0] r_acc;
    logic [31:0] r_win [16];
    logic [31:0] n_w;
    logic [31:0] n_in;

    assign n_w = sha256_pkg::small_sigma1(r_win[14]) + r_win[9]
               + sha256_pkg::small_sigma0(r_win[1]) + r_win[0];
    assign n_in = i_ctl.push ? {r_acc, i_ctl.data} : n_w;
    assign o_w = r_win[0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_acc <= {r_acc[15:0], i_ctl.data};
        end
        if ((i_ctl.push && i_ctl.word_done) || i_ctl.shift) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[15] <= n_in;
        end
    end

endmodule

>>> rtl/sha256_core.sv
// Compression core: eight chaining words, eight working variables and the
// shared round unit, one round per cycle while round is set. Uses sha256_pkg.
`timescale 1ns / 1ps

module sha256_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha256_pkg::t_core_ctl i_ctl,
    input  logic [31:0]           i_w,
    input  logic [2:0]            i_idx,
    output logic [31:0]           o_word
);

    logic [31:0] r_chain [8];
    logic [31:0] r_v [8];
    logic [31:0] n_t1;
    logic [31:0] n_t2;
    logic [31:0] n_ch;
    logic [31:0] n_maj;

    assign n_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign n_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign n_t1  = r_v[7] + sha256_pkg::big_sigma1(r_v[4]) + n_ch
                 + sha256_pkg::K_TAB[i_ctl.rnd] + i_w;
    assign n_t2  = sha256_pkg::big_sigma0(r_v[0]) + n_maj;
    assign o_word = r_chain[i_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= sha256_pkg::IV_TAB[i];
            end
        end else if (i_ctl.finish) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= r_chain[i] + r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_chain[i];
            end
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + n_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= n_t1 + n_t2;
        end
    end

endmodule

>>> rtl/sha256_chk.sv
// Port-level checker for the SHA-256 byte stream hasher, bound to the top level.
// Depends on assert_macros.svh and sha256_byte_stream_hasher.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha256_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    `SHA_ASSERT_SAME(a_no_input_during_digest, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `SHA_ASSERT_SAME(a_last_on_word_seven, i_clk, i_rst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[34:32] == 3'd7))
    `SHA_ASSERT_NEXT(a_words_in_order, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
    `SHA_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid && s_axis_tready)
    `SHA_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind sha256_byte_stream_hasher sha256_chk u_sha256_chk (.*);
